/* rtl/core/bas_pkg.sv */
// Shared types, constants and the glyph table for the block-average shader.
// Used by the top level, the port checker and the testbench.
package bas_pkg;

  // geometry limits
  localparam int MAX_TILE_COLUMNS = 256;
  localparam int MAX_TILE_SIDE    = 64;
  localparam int MAX_IMAGE_WIDTH  = 4096;

  // shade quantization
  localparam int SHADE_COUNT = 8;
  localparam int SHADE_SHIFT = $clog2(256 / SHADE_COUNT);
  localparam logic [2:0] SHADE_MAX = 3'(SHADE_COUNT - 1);

  // luma weights in 16-bit fixed point
  localparam logic [15:0] LUMA_RED   = 16'd19595;
  localparam logic [15:0] LUMA_GREEN = 16'd38470;
  localparam logic [15:0] LUMA_BLUE  = 16'd7471;

  // register reset values
  localparam logic [12:0] IMAGE_WIDTH_RST = 13'd640;
  localparam logic [6:0]  TILE_WIDTH_RST  = 7'd8;
  localparam logic [6:0]  TILE_HEIGHT_RST = 7'd8;

  // field widths
  localparam int SUM_W    = 20;
  localparam int COLOUR_W = 24;
  localparam int AREA_W   = 13;
  localparam int DIV_W    = AREA_W + SHADE_SHIFT;
  localparam int CFG_W    = 13;

  // stream packing
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 56;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_IMAGE_WIDTH   = 2'd0,
    CFG_TILE_WIDTH    = 2'd1,
    CFG_TILE_HEIGHT   = 2'd2,
    CFG_INVERT_SHADES = 2'd3
  } cfg_reg_t;

  // glyphs from darkest to brightest
  localparam logic [7:0] SHADE_GLYPHS [SHADE_COUNT] = '{
    8'd64, 8'd35, 8'd37, 8'd42, 8'd124, 8'd45, 8'd46, 8'd160
  };

  function automatic logic [7:0] shade_glyph(input logic [2:0] shade);
    return SHADE_GLYPHS[shade];
  endfunction

  // one finished tile on its way through the shade divider
  typedef struct packed {
    logic [SUM_W-1:0] rem;
    logic [DIV_W-1:0] div;
    logic [2:0]       shade;
    logic             sat;
    logic [7:0]       red;
    logic [7:0]       green;
    logic [7:0]       blue;
    logic [7:0]       column;
    logic [11:0]      row;
    logic             row_end;
  } quant_t;

  // result item
  typedef struct packed {
    logic [11:0] row;
    logic [7:0]  column;
    logic [7:0]  blue;
    logic [7:0]  green;
    logic [7:0]  red;
    logic [2:0]  shade;
    logic [7:0]  glyph;
  } result_t;

endpackage

/* rtl/core/block_average_ascii_shader.sv */
// Top level of the block-average gray shader: tile accumulation and shade output.
// Depends on bas_pkg and bas_ram.
//
//   channel  | direction | handshake             | payload
//   ---------+-----------+-----------------------+------------------------------------
//   in_      | input     | in_tvalid/in_tready   | in_tdata rgb, in_tuser frame_start
//   out_     | output    | out_tvalid/out_tready | out_tdata result, out_tlast row_end
//   cfg_     | input     | cfg_valid/cfg_ready   | cfg_index, cfg_data
//
// One pixel is taken per cycle unless the input stalls. The tile RAM is read when a pixel
// is taken and written as the pixel leaves the accumulate stage; back-to-back pixels of
// the same tile column take the sum from a forwarding register. The shade divider is
// three compare-subtract stages between the accumulate stage and the output register;
// input stalls only when all three and the output register hold results and out_tready
// is low. rst_n is synchronous and clears counters, valid flags and the registers to
// reset values; the tile RAM is not cleared (each tile's first pixel writes its entry).
module block_average_ascii_shader #(
  parameter int MAX_TILE_COLUMNS = bas_pkg::MAX_TILE_COLUMNS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // pixel items
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [bas_pkg::IN_TDATA_W-1:0] in_tdata,  // red[7:0], green[15:8], blue[23:16]
  input  logic                           in_tuser,  // frame_start[0]
  // tile result items
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [bas_pkg::OUT_TDATA_W-1:0] out_tdata, // glyph_code[7:0], shade_level[10:8],
                                                     // tile_red[18:11], tile_green[26:19],
                                                     // tile_blue[34:27], tile_column[42:35],
                                                     // tile_row[54:43], zero[55]
  output logic                            out_tlast, // row_end
  // register writes
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [1:0]                     cfg_index,
  input  logic [bas_pkg::CFG_W-1:0]      cfg_data
);

  localparam int TCI_W  = $clog2(MAX_TILE_COLUMNS + 1);
  localparam int ADDR_W = (MAX_TILE_COLUMNS > 1) ? $clog2(MAX_TILE_COLUMNS) : 1;
  localparam int CMP_W  = TCI_W + 15;
  localparam int ENTRY_W = bas_pkg::COLOUR_W + bas_pkg::SUM_W;
  localparam int QSTAGES = 3;

  // configuration registers
  logic [12:0] image_width_r;
  logic [6:0]  tile_width_r;
  logic [6:0]  tile_height_r;
  logic        invert_shades_r;

  // raster position counters
  logic [11:0]      col_pos_r, col_pos_nxt;
  logic [5:0]       pix_in_tile_r, pix_in_tile_nxt;
  logic [5:0]       row_in_tile_r, row_in_tile_nxt;
  logic [TCI_W-1:0] tile_col_r, tile_col_nxt;
  logic [11:0]      tile_row_r, tile_row_nxt;

  // accumulate stage
  logic                b_valid_r;
  logic                b_write_r;
  logic                b_first_r;
  logic                b_last_r;
  logic                b_row_end_r;
  logic [ADDR_W-1:0]   b_addr_r;
  logic [7:0]          b_column_r;
  logic [11:0]         b_row_r;
  logic [7:0]          b_gray_r;
  logic [bas_pkg::COLOUR_W-1:0] b_colour_r;

  // forwarding of the write that overlapped a read
  logic               fwd_hit_r;
  logic [ENTRY_W-1:0] fwd_data_r;

  // shade divider stages and output register
  logic                   q_valid_r [QSTAGES];
  bas_pkg::quant_t        q_r       [QSTAGES];
  bas_pkg::quant_t        q_step    [QSTAGES];
  logic                   q_go      [QSTAGES];
  logic                   out_valid_r;
  bas_pkg::result_t       out_r;

  // clamped configuration
  logic [12:0] iw_c;
  logic [6:0]  tw_c;
  logic [6:0]  th_c;

  always_comb begin
    iw_c = image_width_r;
    if (image_width_r == 13'd0) begin
      iw_c = 13'd1;
    end else if (image_width_r > 13'(bas_pkg::MAX_IMAGE_WIDTH)) begin
      iw_c = 13'(bas_pkg::MAX_IMAGE_WIDTH);
    end
    tw_c = tile_width_r;
    if (tile_width_r == 7'd0) begin
      tw_c = 7'd1;
    end else if (tile_width_r > 7'(bas_pkg::MAX_TILE_SIDE)) begin
      tw_c = 7'(bas_pkg::MAX_TILE_SIDE);
    end
    th_c = tile_height_r;
    if (tile_height_r == 7'd0) begin
      th_c = 7'd1;
    end else if (tile_height_r > 7'(bas_pkg::MAX_TILE_SIDE)) begin
      th_c = 7'(bas_pkg::MAX_TILE_SIDE);
    end
  end

  // handshakes
  logic in_fire;
  logic b_res;
  logic b_go;
  logic q0_free;
  logic wr_en;

  assign cfg_ready = 1'b1;
  assign in_fire   = in_tvalid && in_tready;
  assign in_tready = !b_valid_r || b_go;

  // input fields
  logic [7:0] px_red, px_green, px_blue;
  logic       frame_start;

  assign px_red      = in_tdata[7:0];
  assign px_green    = in_tdata[15:8];
  assign px_blue     = in_tdata[23:16];
  assign frame_start = in_tuser;

  // counters as seen by this pixel, after a frame start
  logic [11:0]      col_pos_e;
  logic [5:0]       pix_e, row_e;
  logic [TCI_W-1:0] tile_col_e;
  logic [11:0]      tile_row_e;

  assign col_pos_e  = frame_start ? 12'd0 : col_pos_r;
  assign pix_e      = frame_start ? 6'd0 : pix_in_tile_r;
  assign row_e      = frame_start ? 6'd0 : row_in_tile_r;
  assign tile_col_e = frame_start ? '0 : tile_col_r;
  assign tile_row_e = frame_start ? 12'd0 : tile_row_r;

  // whole-tile test: tile c fits when c < MAX_TILE_COLUMNS and (c + 1) * tw <= iw
  logic [CMP_W-1:0] tile_end, next_end;
  logic             in_range, row_end_a, first_a, last_a;

  assign tile_end  = (CMP_W'(tile_col_e) + CMP_W'(1)) * CMP_W'(tw_c);
  assign next_end  = tile_end + CMP_W'(tw_c);
  assign in_range  = (tile_col_e < TCI_W'(MAX_TILE_COLUMNS)) && (tile_end <= CMP_W'(iw_c));
  assign row_end_a = in_range && ((next_end > CMP_W'(iw_c)) ||
                                  (tile_col_e == TCI_W'(MAX_TILE_COLUMNS - 1)));
  assign first_a   = (pix_e == 6'd0) && (row_e == 6'd0);
  assign last_a    = (7'(pix_e) == tw_c - 7'd1) && (7'(row_e) == th_c - 7'd1);

  // luma in fixed point, truncated
  logic [23:0] luma_acc;

  assign luma_acc = 24'(bas_pkg::LUMA_RED) * 24'(px_red) +
                    24'(bas_pkg::LUMA_GREEN) * 24'(px_green) +
                    24'(bas_pkg::LUMA_BLUE) * 24'(px_blue);

  // next raster position
  logic [6:0]  pix_inc, row_inc;
  logic [12:0] col_inc;

  always_comb begin
    pix_inc         = 7'(pix_e) + 7'd1;
    row_inc         = 7'(row_e) + 7'd1;
    col_inc         = 13'(col_pos_e) + 13'd1;
    pix_in_tile_nxt = pix_inc[5:0];
    tile_col_nxt    = tile_col_e;
    row_in_tile_nxt = row_e;
    tile_row_nxt    = tile_row_e;
    col_pos_nxt     = col_inc[11:0];
    if (pix_inc >= tw_c) begin
      pix_in_tile_nxt = 6'd0;
      if (tile_col_e < TCI_W'(MAX_TILE_COLUMNS)) begin
        tile_col_nxt = tile_col_e + TCI_W'(1);
      end
    end
    if (col_inc >= iw_c) begin
      col_pos_nxt     = 12'd0;
      pix_in_tile_nxt = 6'd0;
      tile_col_nxt    = '0;
      row_in_tile_nxt = row_inc[5:0];
      if (row_inc >= th_c) begin
        row_in_tile_nxt = 6'd0;
        tile_row_nxt    = tile_row_e + 12'd1;
      end
    end
  end

  // tile RAM: sum in the low bits, top-left colour above
  logic [ENTRY_W-1:0] ram_rd_data;
  logic [ENTRY_W-1:0] wr_data;

  bas_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_TILE_COLUMNS)
  ) u_bas_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (b_addr_r),
    .wr_data (wr_data),
    .rd_en   (in_fire),
    .rd_addr (ADDR_W'(tile_col_e)),
    .rd_data (ram_rd_data)
  );

  // read-modify-write of the tile entry
  logic [ENTRY_W-1:0]           src_entry;
  logic [bas_pkg::SUM_W-1:0]    new_sum;
  logic [bas_pkg::COLOUR_W-1:0] new_colour;
  logic [bas_pkg::AREA_W-1:0]   area;

  assign src_entry  = fwd_hit_r ? fwd_data_r : ram_rd_data;
  assign new_sum    = b_first_r ? bas_pkg::SUM_W'(b_gray_r)
                                : src_entry[bas_pkg::SUM_W-1:0] + bas_pkg::SUM_W'(b_gray_r);
  assign new_colour = b_first_r ? b_colour_r : src_entry[ENTRY_W-1:bas_pkg::SUM_W];
  assign wr_data    = {new_colour, new_sum};
  assign area       = bas_pkg::AREA_W'(tw_c) * bas_pkg::AREA_W'(th_c);
  assign b_res      = b_write_r && b_last_r;
  assign b_go       = b_valid_r && (!b_res || q0_free);
  assign wr_en      = b_go && b_write_r;

  // shade divider: each stage settles one shade bit, the first also saturation
  always_comb begin
    logic [20:0] thr;
    logic        ge;
    for (int k = 0; k < QSTAGES; k++) begin
      q_step[k] = q_r[k];
      thr       = 21'(q_r[k].div) << (QSTAGES - 1 - k);
      ge        = 21'(q_r[k].rem) >= thr;
      if (ge) begin
        q_step[k].rem = q_r[k].rem - thr[bas_pkg::SUM_W-1:0];
      end
      q_step[k].shade[QSTAGES - 1 - k] = ge;
      if (k == 0) begin
        q_step[k].sat = 21'(q_r[k].rem) >= (21'(q_r[k].div) << QSTAGES);
      end
    end
  end

  // stage advance, from the output back
  always_comb begin
    q_go[QSTAGES-1] = q_valid_r[QSTAGES-1] && (!out_valid_r || out_tready);
    for (int k = QSTAGES - 2; k >= 0; k--) begin
      q_go[k] = q_valid_r[k] && (!q_valid_r[k+1] || q_go[k+1]);
    end
    q0_free = !q_valid_r[0] || q_go[0];
  end

  // finished result
  logic [2:0]        shade_fin;
  bas_pkg::result_t  res_nxt;

  always_comb begin
    shade_fin     = q_step[QSTAGES-1].sat ? bas_pkg::SHADE_MAX : q_step[QSTAGES-1].shade;
    res_nxt.shade = shade_fin;
    res_nxt.glyph = invert_shades_r ? bas_pkg::shade_glyph(bas_pkg::SHADE_MAX - shade_fin)
                                    : bas_pkg::shade_glyph(shade_fin);
    res_nxt.red    = q_r[QSTAGES-1].red;
    res_nxt.green  = q_r[QSTAGES-1].green;
    res_nxt.blue   = q_r[QSTAGES-1].blue;
    res_nxt.column = q_r[QSTAGES-1].column;
    res_nxt.row    = q_r[QSTAGES-1].row;
  end

  logic out_row_end_r;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r   <= bas_pkg::IMAGE_WIDTH_RST;
      tile_width_r    <= bas_pkg::TILE_WIDTH_RST;
      tile_height_r   <= bas_pkg::TILE_HEIGHT_RST;
      invert_shades_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (bas_pkg::cfg_reg_t'(cfg_index))
        bas_pkg::CFG_IMAGE_WIDTH:   image_width_r   <= cfg_data;
        bas_pkg::CFG_TILE_WIDTH:    tile_width_r    <= cfg_data[6:0];
        bas_pkg::CFG_TILE_HEIGHT:   tile_height_r   <= cfg_data[6:0];
        bas_pkg::CFG_INVERT_SHADES: invert_shades_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // raster counters, forwarding flag and accumulate-stage valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_pos_r     <= 12'd0;
      pix_in_tile_r <= 6'd0;
      row_in_tile_r <= 6'd0;
      tile_col_r    <= '0;
      tile_row_r    <= 12'd0;
      b_valid_r     <= 1'b0;
      fwd_hit_r     <= 1'b0;
    end else begin
      if (in_fire) begin
        col_pos_r     <= col_pos_nxt;
        pix_in_tile_r <= pix_in_tile_nxt;
        row_in_tile_r <= row_in_tile_nxt;
        tile_col_r    <= tile_col_nxt;
        tile_row_r    <= tile_row_nxt;
        fwd_hit_r     <= wr_en && (b_addr_r == ADDR_W'(tile_col_e));
        b_valid_r     <= 1'b1;
      end else if (b_go) begin
        b_valid_r <= 1'b0;
      end
    end
  end

  // accumulate-stage payload and forwarded entry
  always_ff @(posedge clk) begin
    if (in_fire) begin
      b_write_r   <= in_range;
      b_first_r   <= first_a;
      b_last_r    <= last_a;
      b_row_end_r <= row_end_a;
      b_addr_r    <= ADDR_W'(tile_col_e);
      b_column_r  <= 8'(tile_col_e);
      b_row_r     <= tile_row_e;
      b_gray_r    <= luma_acc[23:16];
      b_colour_r  <= {px_red, px_green, px_blue};
      fwd_data_r  <= wr_data;
    end
  end

  // divider valid flags and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < QSTAGES; k++) begin
        q_valid_r[k] <= 1'b0;
      end
      out_valid_r <= 1'b0;
    end else begin
      if (b_go && b_res) begin
        q_valid_r[0] <= 1'b1;
      end else if (q_go[0]) begin
        q_valid_r[0] <= 1'b0;
      end
      for (int k = 1; k < QSTAGES; k++) begin
        if (q_go[k-1]) begin
          q_valid_r[k] <= 1'b1;
        end else if (q_go[k]) begin
          q_valid_r[k] <= 1'b0;
        end
      end
      if (q_go[QSTAGES-1]) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // divider and output payload
  always_ff @(posedge clk) begin
    if (b_go && b_res) begin
      q_r[0].rem     <= new_sum;
      q_r[0].div     <= {area, bas_pkg::SHADE_SHIFT'(0)};
      q_r[0].shade   <= 3'd0;
      q_r[0].sat     <= 1'b0;
      q_r[0].red     <= new_colour[23:16];
      q_r[0].green   <= new_colour[15:8];
      q_r[0].blue    <= new_colour[7:0];
      q_r[0].column  <= b_column_r;
      q_r[0].row     <= b_row_r;
      q_r[0].row_end <= b_row_end_r;
    end
    for (int k = 1; k < QSTAGES; k++) begin
      if (q_go[k-1]) begin
        q_r[k] <= q_step[k-1];
      end
    end
    if (q_go[QSTAGES-1]) begin
      out_r         <= res_nxt;
      out_row_end_r <= q_r[QSTAGES-1].row_end;
    end
  end

  // result port
  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_row_end_r;
  assign out_tdata  = bas_pkg::OUT_TDATA_W'(out_r);

endmodule

/* rtl/core/bas_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
module bas_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // registered read port, holds when not enabled
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* rtl/core/bas_checker.sv */
// Port-level checker for the block-average shader, bound to the top level.
// Depends on bas_pkg.
module bas_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [bas_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                            out_tlast
);

  logic [7:0] glyph;
  logic [2:0] shade;

  assign glyph = out_tdata[7:0];
  assign shade = out_tdata[10:8];

  // reset empties the result register
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // a stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled result changed");

  // glyph follows the shade, in one table order or the other
  a_glyph_shade: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (glyph == bas_pkg::shade_glyph(shade)) ||
                   (glyph == bas_pkg::shade_glyph(bas_pkg::SHADE_MAX - shade)))
    else $error("glyph does not match shade");

  // padding bit stays low
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !out_tdata[bas_pkg::OUT_TDATA_W-1])
    else $error("padding bit set");

endmodule

bind block_average_ascii_shader bas_checker u_bas_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

/* tb/block_average_ascii_shader_tb.sv */
// Self-checking testbench for block_average_ascii_shader: streams RGB pixels, predicts
// each tile's shade, glyph, colour and position, and checks every result item in order.
// Depends on bas_pkg and the block's RTL only.
`timescale 1ns / 1ps

module block_average_ascii_shader_tb;

  // shading arithmetic
  localparam int unsigned LUMA_R      = 19595;
  localparam int unsigned LUMA_G      = 38470;
  localparam int unsigned LUMA_B      = 7471;
  localparam int unsigned SHADE_STEP  = 32;
  localparam int unsigned SHADE_TOP   = 7;
  localparam int unsigned MAX_COLUMNS = 256;
  localparam int unsigned MAX_SIDE    = 64;
  localparam int unsigned MAX_WIDTH   = 4096;
  localparam logic [7:0]  GLYPHS [8]  = '{"@", "#", "%", "*", "|", "-", ".", 8'd160};

  // register values after reset
  localparam logic [12:0] DEFAULT_IMAGE_WIDTH = 13'd640;
  localparam logic [6:0]  DEFAULT_TILE_SIDE   = 7'd8;

  // run control
  localparam int DRAIN_CYCLES  = 16;
  localparam int RANDOM_PIXELS = 600;
  localparam int FRAME_CAP     = 200;
  localparam int STALL_HOLD    = 300;
  localparam int CYCLE_LIMIT   = 200_000;

  // tones from which the channel values of a frame are drawn
  typedef enum {TONE_ANY, TONE_DARK, TONE_BRIGHT, TONE_NEAR} tone_t;

  typedef struct packed {
    bas_pkg::result_t data;
    logic             last;
  } tile_expect_t;

  // colour probes for the luma weights and every shade boundary, {red, green, blue}
  localparam logic [23:0] PROBE_COLOURS [19] = '{
    24'h000000, 24'hFFFFFF, 24'hFF0000, 24'h00FF00, 24'h0000FF,
    24'h1F1F1F, 24'h202020, 24'h3F3F3F, 24'h404040, 24'h5F5F5F,
    24'h606060, 24'h7F7F7F, 24'h808080, 24'h9F9F9F, 24'hA0A0A0,
    24'hBFBFBF, 24'hC0C0C0, 24'hDFDFDF, 24'hE0E0E0
  };

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;   // red[7:0], green[15:8], blue[23:16]
  logic        in_tuser;   // frame_start[0]
  logic        out_tvalid;
  logic        out_tready;
  logic [55:0] out_tdata;  // glyph_code[7:0], shade_level[10:8], tile_red[18:11],
                           // tile_green[26:19], tile_blue[34:27], tile_column[42:35],
                           // tile_row[54:43], zero[55]
  logic        out_tlast;  // row_end
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [12:0] cfg_data;

  // shadow registers and tile state of the predictor
  logic [12:0] image_width_reg;
  logic [6:0]  tile_width_reg;
  logic [6:0]  tile_height_reg;
  logic        invert_reg;
  int unsigned col_pos;
  int unsigned row_in_tile;
  int unsigned pix_in_tile;
  int unsigned tile_col;
  logic [11:0] tile_row;
  logic [19:0] tile_sum [MAX_COLUMNS];
  logic [23:0] tile_colour [MAX_COLUMNS];
  bit          tile_written [MAX_COLUMNS];

  tile_expect_t expected_tiles [$];
  int           mismatches;
  int           sent_pixels;
  int           hold_request;
  bit           steady_flow;

  block_average_ascii_shader uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // out-of-range sizes act as the nearest legal one
  function automatic int unsigned clamp_side(input int unsigned v, input int unsigned hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int unsigned tile_columns();
    int unsigned n;
    n = clamp_side(image_width_reg, MAX_WIDTH) / clamp_side(tile_width_reg, MAX_SIDE);
    return (n > MAX_COLUMNS) ? MAX_COLUMNS : n;
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 60) return 0;
    if (p < 88) return $urandom_range(1, 3);
    if (p < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 50);
  endfunction

  function automatic logic [7:0] pick_level(input tone_t tone, input int unsigned base);
    int unsigned v;
    case (tone)
      TONE_DARK:   v = $urandom_range(0, 40);
      TONE_BRIGHT: v = $urandom_range(215, 255);
      TONE_NEAR:   v = base + $urandom_range(0, 31);
      default:     v = $urandom_range(0, 255);
    endcase
    if (v > 255) v = 255;
    return v[7:0];
  endfunction

  function automatic int unsigned pick_width();
    case ($urandom_range(0, 19))
      0:       return 0;
      1:       return $urandom_range(4097, 8191);
      2:       return $urandom_range(41, 4096);
      default: return $urandom_range(1, 40);
    endcase
  endfunction

  function automatic int unsigned pick_side(input int unsigned usual_max);
    case ($urandom_range(0, 9))
      0:       return 0;
      1:       return $urandom_range(65, 127);
      2:       return $urandom_range(usual_max + 1, MAX_SIDE);
      default: return $urandom_range(1, usual_max);
    endcase
  endfunction

  // predictor: one accepted pixel, pushes the tile result it completes
  task automatic shade_pixel(input logic [7:0] red, input logic [7:0] green,
                             input logic [7:0] blue, input logic new_frame);
    int unsigned iw, tw, th, ncols, gray, shade, c;
    tile_expect_t tile;
    iw    = clamp_side(image_width_reg, MAX_WIDTH);
    tw    = clamp_side(tile_width_reg, MAX_SIDE);
    th    = clamp_side(tile_height_reg, MAX_SIDE);
    ncols = tile_columns();
    if (new_frame) begin
      col_pos     = 0;
      row_in_tile = 0;
      pix_in_tile = 0;
      tile_col    = 0;
      tile_row    = '0;
    end
    gray = (LUMA_R * red + LUMA_G * green + LUMA_B * blue) >> 16;
    c    = tile_col;

    // accumulate into this column's tile, first pixel restarts it
    if (c < ncols) begin
      if (pix_in_tile == 0 && row_in_tile == 0) begin
        tile_sum[c]     = gray[19:0];
        tile_colour[c]  = {red, green, blue};
        tile_written[c] = 1'b1;
      end else begin
        tile_sum[c] = tile_sum[c] + gray[19:0];
      end
      if (pix_in_tile == tw - 1 && row_in_tile == th - 1) begin
        shade = (tile_sum[c] / (tw * th)) / SHADE_STEP;
        if (shade > SHADE_TOP) shade = SHADE_TOP;
        tile.data.glyph  = GLYPHS[invert_reg ? SHADE_TOP - shade : shade];
        tile.data.shade  = shade[2:0];
        tile.data.red    = tile_colour[c][23:16];
        tile.data.green  = tile_colour[c][15:8];
        tile.data.blue   = tile_colour[c][7:0];
        tile.data.column = c[7:0];
        tile.data.row    = tile_row;
        tile.last        = (c == ncols - 1);
        expected_tiles.push_back(tile);
      end
    end

    // advance the raster position
    pix_in_tile++;
    if (pix_in_tile >= tw) begin
      pix_in_tile = 0;
      if (tile_col < MAX_COLUMNS) tile_col++;
    end
    col_pos++;
    if (col_pos >= iw) begin
      col_pos     = 0;
      pix_in_tile = 0;
      tile_col    = 0;
      row_in_tile++;
      if (row_in_tile >= th) begin
        row_in_tile = 0;
        tile_row    = tile_row + 1'b1;
      end
    end
  endtask

  // offer one pixel item and wait for it to be taken
  task automatic send_pixel(input logic [7:0] red, input logic [7:0] green,
                            input logic [7:0] blue, input logic new_frame);
    int gap;
    int unsigned c;
    gap = steady_flow ? 0 : pick_gap();
    c   = tile_col;
    // never continue a tile whose accumulator was never started
    if (!new_frame && c < tile_columns() && !(pix_in_tile == 0 && row_in_tile == 0) &&
        !tile_written[c])
      new_frame = 1'b1;
    repeat (gap) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= {blue, green, red};
    in_tuser  <= new_frame;
    do @(posedge clk); while (!in_tready);
    shade_pixel(red, green, blue, new_frame);
    sent_pixels++;
  endtask

  task automatic send_frame(input int count, input bit restart, input tone_t tone,
                            input bit noisy);
    int unsigned base;
    base = $urandom_range(0, 255);
    for (int k = 0; k < count; k++)
      send_pixel(pick_level(tone, base), pick_level(tone, base), pick_level(tone, base),
                 (restart && k == 0) || (noisy && $urandom_range(0, 149) == 0));
  endtask

  task automatic wait_drained();
    while (expected_tiles.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // register write, only once the block has gone quiet
  task automatic write_reg(input bas_pkg::cfg_reg_t idx, input logic [12:0] value);
    @(negedge clk);
    in_tvalid <= 1'b0;
    wait_drained();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      bas_pkg::CFG_IMAGE_WIDTH: image_width_reg = value;
      bas_pkg::CFG_TILE_WIDTH:  tile_width_reg  = value[6:0];
      bas_pkg::CFG_TILE_HEIGHT: tile_height_reg = value[6:0];
      default:                  invert_reg      = value[0];
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_geometry(input int unsigned width, input int unsigned tw,
                              input int unsigned th, input bit invert);
    write_reg(bas_pkg::CFG_IMAGE_WIDTH, width[12:0]);
    write_reg(bas_pkg::CFG_TILE_WIDTH, tw[12:0]);
    write_reg(bas_pkg::CFG_TILE_HEIGHT, th[12:0]);
    write_reg(bas_pkg::CFG_INVERT_SHADES, {12'd0, invert});
  endtask

  task automatic note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("%s", msg);
  endtask

  // default 640 wide image with 8x8 tiles: the first pixels complete no tile
  task automatic test_reset_geometry();
    send_frame(96, 1'b1, TONE_ANY, 1'b0);
  endtask

  // luma weights and every shade boundary, both glyph orders
  task automatic test_luma_levels();
    set_geometry(4, 1, 1, 1'b0);
    for (int inv = 0; inv < 2; inv++) begin
      write_reg(bas_pkg::CFG_INVERT_SHADES, 13'(inv));
      for (int k = 0; k < 19; k++)
        send_pixel(PROBE_COLOURS[k][23:16], PROBE_COLOURS[k][15:8], PROBE_COLOURS[k][7:0],
                   k == 0);
    end
  endtask

  // partial columns and rows, zero sizes, restarts inside a frame, tiles wider than rows
  task automatic test_tile_shapes();
    set_geometry(7, 3, 2, 1'b0);
    send_frame(35, 1'b1, TONE_ANY, 1'b0);
    set_geometry(0, 0, 0, 1'b1);
    send_frame(3, 1'b1, TONE_ANY, 1'b0);
    set_geometry(5, 2, 3, 1'b0);
    send_frame(12, 1'b1, TONE_NEAR, 1'b0);
    send_frame(30, 1'b1, TONE_BRIGHT, 1'b0);
    set_geometry(3, 5, 1, 1'b1);
    send_frame(6, 1'b1, TONE_DARK, 1'b0);
    set_geometry(9, 4, 1, 1'b0);
    send_frame(20, 1'b0, TONE_ANY, 1'b0);
  endtask

  // column limit of the accumulators, and the widest image with oversize tiles
  task automatic test_wide_rows();
    set_geometry(300, 1, 1, 1'b0);
    send_frame(300, 1'b1, TONE_ANY, 1'b0);
    set_geometry(8191, 127, 1, 1'b1);
    send_frame(128, 1'b1, TONE_ANY, 1'b0);
  endtask

  // widest tile, all white
  task automatic test_full_tile();
    set_geometry(64, 64, 4, 1'b1);
    for (int k = 0; k < 256; k++) send_pixel(8'hFF, 8'hFF, 8'hFF, k == 0);
  endtask

  // one-pixel tiles in a one-pixel column, a result for every pixel
  task automatic test_single_column();
    set_geometry(1, 1, 1, 1'b0);
    send_frame(48, 1'b1, TONE_ANY, 1'b0);
  endtask

  // receiver holds off while pixels keep coming, so the block must stall its input
  task automatic test_output_stall();
    set_geometry(2, 1, 1, 1'b0);
    hold_request = STALL_HOLD;
    steady_flow  = 1'b1;
    send_frame(80, 1'b1, TONE_ANY, 1'b0);
    steady_flow  = 1'b0;
  endtask

  // random geometry, frames of random length, some reconfigured mid-frame and broken by restarts
  task automatic test_random_frames();
    int goal, frames, rows, count, iw, th;
    bas_pkg::cfg_reg_t idx;
    goal = sent_pixels + RANDOM_PIXELS;
    set_geometry(pick_width(), pick_side(6), pick_side(4), 1'($urandom_range(0, 1)));
    while (sent_pixels < goal) begin
      if ($urandom_range(0, 2) == 0) begin
        idx = bas_pkg::cfg_reg_t'($urandom_range(0, 3));
        case (idx)
          bas_pkg::CFG_IMAGE_WIDTH: write_reg(idx, 13'(pick_width()));
          bas_pkg::CFG_TILE_WIDTH:  write_reg(idx, 13'(pick_side(6)));
          bas_pkg::CFG_TILE_HEIGHT: write_reg(idx, 13'(pick_side(4)));
          default:                  write_reg(idx, 13'($urandom_range(0, 1)));
        endcase
      end else begin
        set_geometry(pick_width(), pick_side(6), pick_side(4), 1'($urandom_range(0, 1)));
      end
      frames = $urandom_range(1, 3);
      for (int f = 0; f < frames; f++) begin
        iw    = clamp_side(image_width_reg, MAX_WIDTH);
        th    = clamp_side(tile_height_reg, MAX_SIDE);
        rows  = $urandom_range(1, 3 * th);
        count = iw * rows + $urandom_range(0, iw - 1);
        if (count > FRAME_CAP) count = FRAME_CAP;
        if (count > goal - sent_pixels) count = goal - sent_pixels;
        steady_flow = ($urandom_range(0, 4) == 0);
        send_frame(count, f > 0 || $urandom_range(0, 3) != 0,
                   tone_t'($urandom_range(0, 3)), 1'b1);
      end
      steady_flow = 1'b0;
    end
  endtask

  // receiver pacing: random stalls, a requested long hold, no new random stalls in steady stretches
  initial begin : sink_pacing
    int stall_left;
    stall_left = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        stall_left   = hold_request;
        hold_request = 0;
      end else if (stall_left == 0 && !steady_flow) begin
        stall_left = pick_gap();
      end
      if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // compare each result item with the oldest expected tile
  always @(posedge clk) begin : check_tiles
    tile_expect_t tile;
    bas_pkg::result_t seen;
    if (rst_n && out_tvalid && out_tready) begin
      seen = out_tdata[54:0];
      if (expected_tiles.size() == 0) begin
        note_mismatch($sformatf("unexpected tile item: tdata %h last %b", out_tdata,
                                out_tlast));
      end else begin
        tile = expected_tiles.pop_front();
        if (seen.glyph !== tile.data.glyph || seen.shade !== tile.data.shade ||
            seen.red !== tile.data.red || seen.green !== tile.data.green ||
            seen.blue !== tile.data.blue || seen.column !== tile.data.column ||
            seen.row !== tile.data.row || out_tdata[55] !== 1'b0 ||
            out_tlast !== tile.last)
          note_mismatch($sformatf({"tile mismatch: expected row %0d col %0d glyph %h ",
            "shade %0d rgb %h%h%h last %b; got row %0d col %0d glyph %h shade %0d ",
            "rgb %h%h%h last %b pad %b"},
            tile.data.row, tile.data.column, tile.data.glyph, tile.data.shade,
            tile.data.red, tile.data.green, tile.data.blue, tile.last,
            seen.row, seen.column, seen.glyph, seen.shade,
            seen.red, seen.green, seen.blue, out_tlast, out_tdata[55]));
      end
    end
  end

  // watchdog
  initial begin : run_limit
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("block_average_ascii_shader regression: fail");
    $finish;
  end

  initial begin
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tuser     = 1'b0;
    cfg_valid    = 1'b0;
    cfg_index    = bas_pkg::CFG_IMAGE_WIDTH;
    cfg_data     = '0;
    mismatches   = 0;
    sent_pixels  = 0;
    hold_request = 0;
    steady_flow  = 1'b0;

    // predictor starts from the reset state
    image_width_reg = DEFAULT_IMAGE_WIDTH;
    tile_width_reg  = DEFAULT_TILE_SIDE;
    tile_height_reg = DEFAULT_TILE_SIDE;
    invert_reg      = 1'b0;
    col_pos         = 0;
    row_in_tile     = 0;
    pix_in_tile     = 0;
    tile_col        = 0;
    tile_row        = '0;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_geometry();
    test_luma_levels();
    test_tile_shapes();
    test_wide_rows();
    test_full_tile();
    test_single_column();
    test_output_stall();
    test_random_frames();

    @(negedge clk);
    in_tvalid <= 1'b0;
    wait_drained();
    if (mismatches == 0 && expected_tiles.size() == 0)
      $display("block_average_ascii_shader regression: pass");
    else
      $display("block_average_ascii_shader regression: fail");
    $finish;
  end

endmodule

/* block_average_ascii_shader.f */
rtl/core/bas_pkg.sv
rtl/core/bas_ram.sv
rtl/core/block_average_ascii_shader.sv
rtl/core/bas_checker.sv
tb/block_average_ascii_shader_tb.sv
